// ===== rtl/tct_pkg.sv =====
// shared types and constants of the touch calibration transform
package tct_pkg;

  localparam int unsigned RawW  = 12;
  localparam int unsigned CoefW = 32;
  localparam int unsigned OffW  = 48;
  localparam int unsigned ProdW = CoefW + RawW + 1;
  localparam int unsigned NumW  = 50;
  localparam int unsigned QW    = 17;
  localparam int unsigned DispW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = OffW;

  localparam logic [CfgIdxW-1:0] REG_COEF_A    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_COEF_B    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COEF_C    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_COEF_D    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_COEF_E    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_COEF_F    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DIVISOR_K = 3'd6;

  typedef struct packed {
    logic [NumW-1:0] rem_x;
    logic [NumW-1:0] rem_y;
    logic [QW-1:0]   q_x;
    logic [QW-1:0]   q_y;
    logic            neg_x;
    logic            neg_y;
    logic            ovf_x;
    logic            ovf_y;
  } div_t;

endpackage

// ===== rtl/tct_mac.sv =====
// products, numerator sums and magnitude setup ahead of the divider row
module tct_mac import tct_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [CoefW-1:0] coef_a_i,
  input  logic signed [CoefW-1:0] coef_b_i,
  input  logic signed [OffW-1:0]  coef_c_i,
  input  logic signed [CoefW-1:0] coef_d_i,
  input  logic signed [CoefW-1:0] coef_e_i,
  input  logic signed [OffW-1:0]  coef_f_i,
  input  logic signed [CoefW-1:0] divisor_k_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [RawW-1:0]         raw_x_i,
  input  logic [RawW-1:0]         raw_y_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output div_t                    data_o
);

  logic signed [RawW:0] xs, ys;
  logic signed [ProdW-1:0] pa_q, pb_q, pd_q, pe_q;
  logic signed [NumW-1:0] nx_q, ny_q;
  logic v1_q, v2_q, v3_q;
  logic r1, r2, r3;
  logic [NumW-1:0] mag_x, mag_y, lim;
  logic [CoefW-1:0] dk;
  div_t d3_q;

  assign xs = $signed({1'b0, raw_x_i});
  assign ys = $signed({1'b0, raw_y_i});

  assign r3 = !v3_q || ready_i;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign ready_o = r1;

  assign mag_x = nx_q[NumW-1] ? NumW'(-nx_q) : NumW'(nx_q);
  assign mag_y = ny_q[NumW-1] ? NumW'(-ny_q) : NumW'(ny_q);
  assign dk = divisor_k_i[CoefW-1] ? CoefW'(-divisor_k_i) : CoefW'(divisor_k_i);
  assign lim = NumW'(dk) << QW;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) begin
      pa_q <= ProdW'(coef_a_i * xs);
      pb_q <= ProdW'(coef_b_i * ys);
      pd_q <= ProdW'(coef_d_i * xs);
      pe_q <= ProdW'(coef_e_i * ys);
    end
    if (r2 && v1_q) begin
      nx_q <= NumW'(pa_q) + NumW'(pb_q) + NumW'(coef_c_i);
      ny_q <= NumW'(pd_q) + NumW'(pe_q) + NumW'(coef_f_i);
    end
    if (r3 && v2_q) begin
      d3_q.rem_x <= mag_x;
      d3_q.rem_y <= mag_y;
      d3_q.q_x   <= '0;
      d3_q.q_y   <= '0;
      d3_q.neg_x <= nx_q[NumW-1] ^ divisor_k_i[CoefW-1];
      d3_q.neg_y <= ny_q[NumW-1] ^ divisor_k_i[CoefW-1];
      d3_q.ovf_x <= mag_x >= lim;
      d3_q.ovf_y <= mag_y >= lim;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = d3_q;

endmodule

// ===== rtl/tct_div_cell.sv =====
// one restoring division cell: settles one quotient bit for x and y
module tct_div_cell import tct_pkg::*; #(
  parameter int unsigned Bit = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CoefW-1:0] dk_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  div_t             data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output div_t             data_o
);

  logic valid_q;
  div_t data_q, data_d;
  logic [NumW-1:0] sub;
  logic ge_x, ge_y;

  assign sub  = NumW'(dk_i) << Bit;
  assign ge_x = data_i.rem_x >= sub;
  assign ge_y = data_i.rem_y >= sub;

  always_comb begin
    data_d = data_i;
    if (ge_x) begin
      data_d.rem_x    = data_i.rem_x - sub;
      data_d.q_x[Bit] = 1'b1;
    end
    if (ge_y) begin
      data_d.rem_y    = data_i.rem_y - sub;
      data_d.q_y[Bit] = 1'b1;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/tct_sat.sv =====
// sign restore, clamp to 16 bits and output register
module tct_sat import tct_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    k_nz_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  div_t                    data_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic signed [DispW-1:0] disp_x_o,
  output logic signed [DispW-1:0] disp_y_o,
  output logic                    valid_res_o,
  output logic                    saturated_o
);

  localparam logic [QW-1:0] PosMax = QW'(2 ** (DispW - 1) - 1);
  localparam logic [QW-1:0] NegMax = QW'(2 ** (DispW - 1));

  logic valid_q;
  logic [DispW-1:0] x_q, y_q, x_d, y_d;
  logic vr_q, sat_q, sx, sy;

  always_comb begin
    sx = 1'b0;
    sy = 1'b0;
    if (data_i.neg_x) begin
      sx  = data_i.ovf_x || (data_i.q_x > NegMax);
      x_d = sx ? DispW'(NegMax) : DispW'(~data_i.q_x + 1'b1);
    end else begin
      sx  = data_i.ovf_x || (data_i.q_x > PosMax);
      x_d = sx ? DispW'(PosMax) : DispW'(data_i.q_x);
    end
    if (data_i.neg_y) begin
      sy  = data_i.ovf_y || (data_i.q_y > NegMax);
      y_d = sy ? DispW'(NegMax) : DispW'(~data_i.q_y + 1'b1);
    end else begin
      sy  = data_i.ovf_y || (data_i.q_y > PosMax);
      y_d = sy ? DispW'(PosMax) : DispW'(data_i.q_y);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q   <= k_nz_i ? x_d : '0;
      y_q   <= k_nz_i ? y_d : '0;
      vr_q  <= k_nz_i;
      sat_q <= k_nz_i && (sx || sy);
    end
  end

  assign valid_o     = valid_q;
  assign disp_x_o    = $signed(x_q);
  assign disp_y_o    = $signed(y_q);
  assign valid_res_o = vr_q;
  assign saturated_o = sat_q;

endmodule

// ===== rtl/touch_calibration_transform_top.sv =====
// touch calibration transform: raw touch sample to display coordinates
//
// software loads coef_a..coef_f and divisor_k through the write port
// (cfg_we_i, cfg_index_i, cfg_wdata_i) while no transaction is in flight.
// a raw sample enters on the in_* valid/ready channel; one result leaves
// on the out_* valid/ready channel with disp_x, disp_y, valid_res and
// saturated. a zero divisor gives valid_res = 0 and zero coordinates.
// the pipeline has two multiply/add stages, one magnitude stage, a row
// of 17 division cells (one quotient bit each) and one clamp stage.
// throughput is one transaction per cycle unless the receiver stalls;
// every stage has its own valid bit, so bubbles close up and a stalled
// receiver holds the row while free stages keep accepting. reset clears
// the configuration registers and all valid bits and empties the pipeline.
module touch_calibration_transform_top import tct_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [RawW-1:0]         raw_x_i,
  input  logic [RawW-1:0]         raw_y_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DispW-1:0] disp_x_o,
  output logic signed [DispW-1:0] disp_y_o,
  output logic                    valid_res_o,
  output logic                    saturated_o
);

  logic signed [CoefW-1:0] a_q, b_q, d_q, e_q, k_q;
  logic signed [OffW-1:0]  c_q, f_q;
  logic [CoefW-1:0] dk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
      c_q <= '0;
      d_q <= '0;
      e_q <= '0;
      f_q <= '0;
      k_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_COEF_A:    a_q <= $signed(cfg_wdata_i[CoefW-1:0]);
        REG_COEF_B:    b_q <= $signed(cfg_wdata_i[CoefW-1:0]);
        REG_COEF_C:    c_q <= $signed(cfg_wdata_i[OffW-1:0]);
        REG_COEF_D:    d_q <= $signed(cfg_wdata_i[CoefW-1:0]);
        REG_COEF_E:    e_q <= $signed(cfg_wdata_i[CoefW-1:0]);
        REG_COEF_F:    f_q <= $signed(cfg_wdata_i[OffW-1:0]);
        REG_DIVISOR_K: k_q <= $signed(cfg_wdata_i[CoefW-1:0]);
        default: ;
      endcase
    end
  end

  assign dk = k_q[CoefW-1] ? CoefW'(-k_q) : CoefW'(k_q);

  logic       v [QW+1];
  logic       r [QW+1];
  div_t       s [QW+1];

  tct_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_a_i    (a_q),
    .coef_b_i    (b_q),
    .coef_c_i    (c_q),
    .coef_d_i    (d_q),
    .coef_e_i    (e_q),
    .coef_f_i    (f_q),
    .divisor_k_i (k_q),
    .valid_i     (in_valid_i),
    .ready_o     (in_ready_o),
    .raw_x_i     (raw_x_i),
    .raw_y_i     (raw_y_i),
    .valid_o     (v[0]),
    .ready_i     (r[0]),
    .data_o      (s[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    tct_div_cell #(.Bit(QW - 1 - i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .dk_i    (dk),
      .valid_i (v[i]),
      .ready_o (r[i]),
      .data_i  (s[i]),
      .valid_o (v[i+1]),
      .ready_i (r[i+1]),
      .data_o  (s[i+1])
    );
  end

  tct_sat u_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .k_nz_i      (k_q != '0),
    .valid_i     (v[QW]),
    .ready_o     (r[QW]),
    .data_i      (s[QW]),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .disp_x_o    (disp_x_o),
    .disp_y_o    (disp_y_o),
    .valid_res_o (valid_res_o),
    .saturated_o (saturated_o)
  );

endmodule

// ===== sim/touch_calibration_transform_checker.sv =====
// checker for the touch calibration transform: predicts and compares each result
`timescale 1ns / 1ps
module touch_calibration_transform_checker import tct_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [RawW-1:0]         raw_x_i,
  input  logic [RawW-1:0]         raw_y_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [DispW-1:0] disp_x_i,
  input  logic signed [DispW-1:0] disp_y_i,
  input  logic                    valid_res_i,
  input  logic                    saturated_i,
  output int                      errors_o,
  output int                      pending_o
);

  typedef struct packed {
    logic signed [DispW-1:0] dx;
    logic signed [DispW-1:0] dy;
    logic                    vld;
    logic                    sat;
  } point_t;

  longint coef_a, coef_b, coef_c, coef_d, coef_e, coef_f, div_k;
  point_t expected_points[$];

  function automatic longint clamp_coord(longint q, inout logic sat);
    if (q > 32767) begin
      sat = 1'b1;
      return 32767;
    end
    if (q < -32768) begin
      sat = 1'b1;
      return -32768;
    end
    return q;
  endfunction

  function automatic point_t map_point(logic [RawW-1:0] rx, logic [RawW-1:0] ry);
    point_t p;
    longint nx, ny, qx, qy;
    logic sat;
    p = '0;
    sat = 1'b0;
    if (div_k == 0) return p;
    nx = coef_a * longint'(rx) + coef_b * longint'(ry) + coef_c;
    ny = coef_d * longint'(rx) + coef_e * longint'(ry) + coef_f;
    qx = clamp_coord(nx / div_k, sat);
    qy = clamp_coord(ny / div_k, sat);
    p.dx = qx[DispW-1:0];
    p.dy = qy[DispW-1:0];
    p.vld = 1'b1;
    p.sat = sat;
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    point_t e;
    if (!rst_ni) begin
      coef_a <= 0; coef_b <= 0; coef_c <= 0; coef_d <= 0;
      coef_e <= 0; coef_f <= 0; div_k <= 0;
      errors_o <= 0;
      pending_o <= 0;
      expected_points.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_COEF_A:    coef_a <= longint'(signed'(cfg_wdata_i[31:0]));
          REG_COEF_B:    coef_b <= longint'(signed'(cfg_wdata_i[31:0]));
          REG_COEF_C:    coef_c <= longint'(signed'(cfg_wdata_i[47:0]));
          REG_COEF_D:    coef_d <= longint'(signed'(cfg_wdata_i[31:0]));
          REG_COEF_E:    coef_e <= longint'(signed'(cfg_wdata_i[31:0]));
          REG_COEF_F:    coef_f <= longint'(signed'(cfg_wdata_i[47:0]));
          REG_DIVISOR_K: div_k  <= longint'(signed'(cfg_wdata_i[31:0]));
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_points.push_back(map_point(raw_x_i, raw_y_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_points.size() == 0) begin
          $error("unexpected transaction: disp_x %0d disp_y %0d", disp_x_i, disp_y_i);
          errors_o <= errors_o + 1;
        end else begin
          e = expected_points.pop_front();
          if (disp_x_i !== e.dx || disp_y_i !== e.dy || valid_res_i !== e.vld ||
              saturated_i !== e.sat) begin
            errors_o <= errors_o + 1;
            if (disp_x_i !== e.dx) $error("disp_x: expected %0d actual %0d", e.dx, disp_x_i);
            if (disp_y_i !== e.dy) $error("disp_y: expected %0d actual %0d", e.dy, disp_y_i);
            if (valid_res_i !== e.vld)
              $error("valid_res: expected %0b actual %0b", e.vld, valid_res_i);
            if (saturated_i !== e.sat)
              $error("saturated: expected %0b actual %0b", e.sat, saturated_i);
          end
        end
      end
      pending_o <= expected_points.size();
    end
  end

endmodule

// ===== sim/touch_calibration_transform_top_tb.sv =====
// testbench top for the touch calibration transform: stimulus, configuration and verdict
`timescale 1ns / 1ps
module touch_calibration_transform_top_tb;
  import tct_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [RawW-1:0] raw_x_i = '0;
  logic [RawW-1:0] raw_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [DispW-1:0] disp_x_o, disp_y_o;
  logic valid_res_o, saturated_o;
  int errors, pending;
  bit calm = 1'b0;
  bit hold_off = 1'b0;

  always #5 clk_i = ~clk_i;

  touch_calibration_transform_top uut (.*);

  touch_calibration_transform_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .raw_x_i, .raw_y_i,
    .out_valid_i(out_valid_o), .out_ready_i, .disp_x_i(disp_x_o),
    .disp_y_i(disp_y_o), .valid_res_i(valid_res_o), .saturated_i(saturated_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (60) @(negedge clk_i);
        hold_off = 1'b0;
      end
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        n = $urandom_range(1, 10);
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic send_sample(logic [RawW-1:0] rx, logic [RawW-1:0] ry);
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      n = $urandom_range(1, 10);
      repeat (n) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_x_i <= rx;
    raw_y_i <= ry;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic end_burst;
    in_valid_i <= 1'b0;
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  // calibration set: mode 0 realistic, 1 wide random, 2 extremes
  task automatic load_calibration(int mode);
    logic [47:0] v[7];
    for (int i = 0; i < 7; i++) begin
      case (mode)
        0: v[i] = (i == 2 || i == 5) ? 48'(signed'($urandom_range(0, 2000000)) - 1000000)
                                     : 48'(signed'($urandom_range(0, 4000)) - 2000);
        1: v[i] = rand48();
        default: v[i] = (i == 2 || i == 5) ? {$urandom_range(0, 1) ? 1'b1 : 1'b0, 47'h0}
                                           : {16'h0, ($urandom_range(0, 1) ? 32'h80000000
                                                                          : 32'h7fffffff)};
      endcase
    end
    if (mode == 2 && $urandom_range(0, 1)) v[6] = 48'h0000_ffff_ffff;
    if (mode == 0) v[6] = 48'($urandom_range(1, 64));
    if (mode == 1 && $urandom_range(0, 5) == 0) v[6] = 48'($urandom_range(1, 3));
    write_reg(REG_COEF_A, v[0]);
    write_reg(REG_COEF_B, v[1]);
    write_reg(REG_COEF_C, v[2]);
    write_reg(REG_COEF_D, v[3]);
    write_reg(REG_COEF_E, v[4]);
    write_reg(REG_COEF_F, v[5]);
    write_reg(REG_DIVISOR_K, v[6]);
    write_reg(RegUnused, rand48());
  endtask

  initial begin
    int rx, ry;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // zero divisor straight after reset
    send_sample(12'hfff, 12'h000);
    send_sample(12'h000, 12'hfff);
    end_burst();
    drain();
    // exact values, truncation of negative quotients
    write_reg(REG_COEF_A, 48'd3);
    write_reg(REG_COEF_B, 48'hffff_ffff);
    write_reg(REG_COEF_C, 48'hffff_ffff_fff9);
    write_reg(REG_COEF_D, 48'hffff_fffe);
    write_reg(REG_COEF_E, 48'd5);
    write_reg(REG_COEF_F, 48'd7);
    write_reg(REG_DIVISOR_K, 48'hffff_fffd);
    send_sample(12'h000, 12'h000);
    send_sample(12'hfff, 12'hfff);
    send_sample(12'h555, 12'haaa);
    send_sample(12'haaa, 12'h555);
    send_sample(12'h001, 12'h002);
    end_burst();
    drain();
    // saturation both ways
    write_reg(REG_COEF_A, 48'h7fff_ffff);
    write_reg(REG_COEF_B, 48'h8000_0000);
    write_reg(REG_COEF_C, 48'h7fff_ffff_ffff);
    write_reg(REG_COEF_D, 48'h8000_0000);
    write_reg(REG_COEF_E, 48'h7fff_ffff);
    write_reg(REG_COEF_F, 48'h8000_0000_0000);
    write_reg(REG_DIVISOR_K, 48'd1);
    send_sample(12'hfff, 12'h000);
    send_sample(12'h000, 12'hfff);
    send_sample(12'hfff, 12'hfff);
    end_burst();
    drain();
    write_reg(REG_DIVISOR_K, 48'h8000_0000);
    send_sample(12'h000, 12'h000);
    send_sample(12'hfff, 12'hfff);
    end_burst();
    drain();
    for (int phase = 0; phase < 12; phase++) begin
      load_calibration(phase % 3);
      if (phase == 4) hold_off = 1'b1;
      if (phase == 11) calm = 1'b1;
      for (int i = 0; i < 100; i++) begin
        rx = $urandom_range(0, 4095);
        ry = $urandom_range(0, 4095);
        if ($urandom_range(0, 9) == 0) rx = $urandom_range(0, 1) ? 0 : 4095;
        if ($urandom_range(0, 9) == 0) ry = $urandom_range(0, 1) ? 0 : 4095;
        send_sample(rx[RawW-1:0], ry[RawW-1:0]);
      end
      end_burst();
      drain();
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
